// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-edge check: cons must hold whenever ante holds.
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-edge check: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/stpg_pkg.sv
`default_nettype none

package stpg_pkg;

    localparam int MAX_CHANNELS_DEF   = 8;
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ROM_DEPTH_DEF = 1024;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int MAG_W  = 17;
    localparam int GAIN_W = 17;
    localparam int PROD_W = MAG_W + GAIN_W;

    typedef enum logic [1:0] {
        REG_PHASE_STEP    = 2'd0,
        REG_GAIN          = 2'd1,
        REG_SAMPLE_BYTES  = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } reg_idx_t;

    localparam logic [31:0]       PHASE_STEP_RST    = 32'd97391549;
    localparam logic [GAIN_W-1:0] GAIN_RST          = 17'd23170;
    localparam logic [2:0]        SAMPLE_BYTES_RST  = 3'd2;
    localparam logic [3:0]        CHANNEL_COUNT_RST = 4'd1;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_24 = 2'd2,
        WIDTH_32 = 2'd3
    } width_t;

    typedef struct packed {
        logic [31:0]       phase_step;
        logic [GAIN_W-1:0] gain;
        width_t            width;
    } cfg_t;

    localparam logic [PROD_W-1:0] ONE_Q33     = PROD_W'(64'h2_0000_0000);
    localparam logic [7:0]        BYTE_OFFSET = 8'd128;
    localparam logic [MAG_W-1:0]  MAG_MAX     = 17'd131071;

    // Taylor series of sin(x), x in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 12;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // Entry k of a quarter-wave table with 2**addr_w entries, Q0.17.
    function automatic logic [MAG_W-1:0] sine_entry(int unsigned k, int unsigned addr_w);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        x = (HALF_PI_Q30 * (2 * longint'(k) + 1)) >> (addr_w + 1);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int n = 0; n < TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        r = (sum + 64'd4096) >> 13;
        if (r > longint'(MAG_MAX)) begin
            r = longint'(MAG_MAX);
        end
        return MAG_W'(r);
    endfunction

    // Microcode
    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_IN_VALID = 2'd1,
        COND_OUT_FREE = 2'd2
    } cond_t;

    typedef struct packed {
        logic ld_phase;
        logic rd_rom;
        logic mul;
        logic clamp;
        logic scale;
        logic load_out;
    } ops_t;

    localparam int STEP_W   = 3;
    localparam int PROG_LEN = 2 ** STEP_W;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_ROM   = 3'd1;
    localparam step_t STEP_MUL   = 3'd2;
    localparam step_t STEP_CLAMP = 3'd3;
    localparam step_t STEP_SCALE = 3'd4;
    localparam step_t STEP_LOAD  = 3'd5;

    typedef struct packed {
        cond_t cond;
        step_t pass_step;
        step_t fail_step;
        ops_t  ops;
    } uword_t;

    localparam ops_t OPS_NONE = '{default: 1'b0};

    localparam uword_t PROGRAM [PROG_LEN] = '{
        '{cond: COND_IN_VALID, pass_step: STEP_ROM, fail_step: STEP_IDLE,
          ops: '{ld_phase: 1'b1, default: 1'b0}},
        '{cond: COND_ALWAYS, pass_step: STEP_MUL, fail_step: STEP_MUL,
          ops: '{rd_rom: 1'b1, default: 1'b0}},
        '{cond: COND_ALWAYS, pass_step: STEP_CLAMP, fail_step: STEP_CLAMP,
          ops: '{mul: 1'b1, default: 1'b0}},
        '{cond: COND_ALWAYS, pass_step: STEP_SCALE, fail_step: STEP_SCALE,
          ops: '{clamp: 1'b1, default: 1'b0}},
        '{cond: COND_ALWAYS, pass_step: STEP_LOAD, fail_step: STEP_LOAD,
          ops: '{scale: 1'b1, default: 1'b0}},
        '{cond: COND_OUT_FREE, pass_step: STEP_IDLE, fail_step: STEP_LOAD,
          ops: '{load_out: 1'b1, default: 1'b0}},
        '{cond: COND_ALWAYS, pass_step: STEP_IDLE, fail_step: STEP_IDLE, ops: OPS_NONE},
        '{cond: COND_ALWAYS, pass_step: STEP_IDLE, fail_step: STEP_IDLE, ops: OPS_NONE}
    };

endpackage

`default_nettype wire

// File: src/sine_tone_pcm_generator_unit.sv
// Sine tone generator: one input item per sample tick, one output item per channel copy.
// Input channel (s_valid/s_ready/s_restart): each accepted item is one tick; restart
// set clears the phase to zero before that tick's sample is taken.
// Output channel (m_*): each tick gives channel_count copies of the sample, one per
// cycle while m_ready is high, channel_index counting from 0, last_in_run on the last.
// Configuration: APB registers phase_step (0x0), gain (0x4), sample_bytes (0x8),
// channel_count (0xC); write them only while the block is idle.
// An accepted item's sample passes the ROM read, multiply, clamp and scale steps, and its
// first copy is offered once the load step has put it in the output stage.
// The microcode program runs 6 steps per tick (one read of the registered sine ROM, one
// 17x17 multiply, clamp, scale, load) and takes a new tick only in its idle step.
// The output stage holds the sample while its copies drain, so the next tick is
// accepted and computed during that time; a stalled receiver holds the copy in place and,
// once the next sample is ready, the program waits in its load step and stops taking ticks.
// Reset: synchronous, active low; clears the phase accumulator, restores register
// defaults and empties the output stage.
`default_nettype none

module sine_tone_pcm_generator_unit #(
    parameter int MAX_CHANNELS   = stpg_pkg::MAX_CHANNELS_DEF,
    parameter int PHASE_BITS     = stpg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ROM_DEPTH = stpg_pkg::SINE_ROM_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_restart,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [31:0]                   m_sample_value,
    output logic        [31:0]                   m_packed_bytes,
    output logic        [2:0]                    m_channel_index,
    output logic                                 m_last_in_run,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stpg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [stpg_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [stpg_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    stpg_pkg::cfg_t     cfg;
    stpg_pkg::ops_t     ctl;
    logic [CH_W-1:0]    ch_last;
    logic               out_free;
    logic signed [31:0] load_val;
    logic [31:0]        load_packed;

    stpg_regs #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .ch_last (ch_last)
    );

    stpg_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    stpg_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .cfg         (cfg),
        .restart     (s_restart),
        .load_val    (load_val),
        .load_packed (load_packed)
    );

    stpg_emitter #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (ctl.load_out),
        .load_val        (load_val),
        .load_packed     (load_packed),
        .ch_last         (ch_last),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_packed_bytes  (m_packed_bytes),
        .m_channel_index (m_channel_index),
        .m_last_in_run   (m_last_in_run)
    );

endmodule

`default_nettype wire

// File: src/stpg_regs.sv
`default_nettype none

module stpg_regs #(
    parameter int MAX_CHANNELS = stpg_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stpg_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [stpg_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [stpg_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output stpg_pkg::cfg_t                       cfg,
    output logic      [CH_W-1:0]                 ch_last
);

    logic [31:0]                 phase_step_reg;
    logic [stpg_pkg::GAIN_W-1:0] gain_reg;
    logic [2:0]                  sample_bytes_reg;
    logic [3:0]                  channel_count_reg;
    stpg_pkg::reg_idx_t          reg_idx;
    logic                        wr_en;
    stpg_pkg::width_t            width_sel;

    assign pready  = 1'b1;
    assign reg_idx = stpg_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg    <= stpg_pkg::PHASE_STEP_RST;
            gain_reg          <= stpg_pkg::GAIN_RST;
            sample_bytes_reg  <= stpg_pkg::SAMPLE_BYTES_RST;
            channel_count_reg <= stpg_pkg::CHANNEL_COUNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                stpg_pkg::REG_PHASE_STEP:    phase_step_reg    <= pwdata;
                stpg_pkg::REG_GAIN:          gain_reg          <= pwdata[16:0];
                stpg_pkg::REG_SAMPLE_BYTES:  sample_bytes_reg  <= pwdata[2:0];
                stpg_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            stpg_pkg::REG_PHASE_STEP:    prdata = phase_step_reg;
            stpg_pkg::REG_GAIN:          prdata = 32'(gain_reg);
            stpg_pkg::REG_SAMPLE_BYTES:  prdata = 32'(sample_bytes_reg);
            stpg_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        unique case (sample_bytes_reg)
            3'd0, 3'd1: width_sel = stpg_pkg::WIDTH_8;
            3'd2:       width_sel = stpg_pkg::WIDTH_16;
            3'd3:       width_sel = stpg_pkg::WIDTH_24;
            default:    width_sel = stpg_pkg::WIDTH_32;
        endcase
    end

    assign cfg = '{phase_step: phase_step_reg, gain: gain_reg, width: width_sel};

    always_comb begin
        int unsigned cnt;
        cnt = 32'(channel_count_reg);
        if (cnt == 0) begin
            cnt = 1;
        end
        if (cnt > MAX_CHANNELS) begin
            cnt = MAX_CHANNELS;
        end
        ch_last = CH_W'(cnt - 1);
    end

endmodule

`default_nettype wire

// File: src/stpg_datapath.sv
`default_nettype none
`include "assert_macros.svh"

module stpg_datapath #(
    parameter int PHASE_BITS     = stpg_pkg::PHASE_BITS_DEF,
    parameter int SINE_ROM_DEPTH = stpg_pkg::SINE_ROM_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire stpg_pkg::ops_t ctl,
    input  wire stpg_pkg::cfg_t cfg,
    input  wire logic           restart,
    output logic signed [31:0]  load_val,
    output logic        [31:0]  load_packed
);

    localparam int ADDR_W     = $clog2(SINE_ROM_DEPTH);
    localparam int QUAD_SHIFT = PHASE_BITS - 2;

    typedef logic [stpg_pkg::MAG_W-1:0] rom_t [SINE_ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
            t[k] = stpg_pkg::sine_entry(unsigned'(k), unsigned'(ADDR_W));
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PHASE_BITS-1:0]            acc_reg;
    logic [PHASE_BITS-1:0]            phase_reg;
    logic [PHASE_BITS-1:0]            start_phase;
    logic [ADDR_W-1:0]                rom_addr;
    logic [stpg_pkg::MAG_W-1:0]       rom_data_reg;
    logic [stpg_pkg::PROD_W-1:0]      prod_reg;
    logic [stpg_pkg::PROD_W-1:0]      prod_next;
    logic [30:0]                      mag_reg;
    logic [30:0]                      mag_next;
    logic [4:0]                       shamt;
    logic [64:0]                      prod_wide;
    logic [64:0]                      scaled;
    logic [31:0]                      mag_ext;
    logic [31:0]                      val;

    assign start_phase = restart ? '0 : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.ld_phase) begin
            acc_reg <= start_phase + PHASE_BITS'(cfg.phase_step);
        end
    end

    assign rom_addr = phase_reg[QUAD_SHIFT-1 -: ADDR_W] ^ {ADDR_W{phase_reg[QUAD_SHIFT]}};

    always_comb begin
        if (ctl.mul) begin
            prod_next = stpg_pkg::PROD_W'(rom_data_reg) * stpg_pkg::PROD_W'(cfg.gain);
        end else begin
            prod_next = (prod_reg > stpg_pkg::ONE_Q33) ? stpg_pkg::ONE_Q33 : prod_reg;
        end
    end

    always_comb begin
        unique case (cfg.width)
            stpg_pkg::WIDTH_8:  shamt = 5'd7;
            stpg_pkg::WIDTH_16: shamt = 5'd15;
            stpg_pkg::WIDTH_24: shamt = 5'd23;
            default:            shamt = 5'd31;
        endcase
        prod_wide = 65'(prod_reg);
        scaled    = (prod_wide << shamt) - prod_wide;
        mag_next  = scaled[63:33];
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_phase) begin
            phase_reg <= start_phase;
        end
        if (ctl.rd_rom) begin
            rom_data_reg <= SINE_ROM[rom_addr];
        end
        if (ctl.mul || ctl.clamp) begin
            prod_reg <= prod_next;
        end
        if (ctl.scale) begin
            mag_reg <= mag_next;
        end
    end

    assign mag_ext  = {1'b0, mag_reg};
    assign val      = phase_reg[PHASE_BITS-1] ? (32'd0 - mag_ext) : mag_ext;
    assign load_val = signed'(val);

    always_comb begin
        unique case (cfg.width)
            stpg_pkg::WIDTH_8:  load_packed = {24'd0, val[7:0] + stpg_pkg::BYTE_OFFSET};
            stpg_pkg::WIDTH_16: load_packed = {16'd0, val[15:0]};
            stpg_pkg::WIDTH_24: load_packed = {8'd0, val[23:0]};
            default:            load_packed = val;
        endcase
    end

    `ASSERT_NEXT(a_clamp_bound, aclk, aresetn, ctl.clamp, prod_reg <= stpg_pkg::ONE_Q33)

endmodule

`default_nettype wire

// File: src/stpg_sequencer.sv
`default_nettype none
`include "assert_macros.svh"

module stpg_sequencer (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire logic      out_free,
    output stpg_pkg::ops_t ctl
);

    stpg_pkg::step_t  step_reg;
    stpg_pkg::step_t  step_next;
    stpg_pkg::uword_t uword;
    logic             cond_ok;

    assign uword = stpg_pkg::PROGRAM[step_reg];

    always_comb begin
        unique case (uword.cond)
            stpg_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            stpg_pkg::COND_IN_VALID: cond_ok = s_valid;
            stpg_pkg::COND_OUT_FREE: cond_ok = out_free;
            default:                 cond_ok = 1'b1;
        endcase
    end

    assign step_next = cond_ok ? uword.pass_step : uword.fail_step;
    assign ctl       = cond_ok ? uword.ops : stpg_pkg::OPS_NONE;
    assign s_ready   = (uword.cond == stpg_pkg::COND_IN_VALID);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= stpg_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    `ASSERT_HOLDS(a_single_op, aclk, aresetn, 1'b1, $onehot0(ctl))
    `ASSERT_NEXT(a_read_follows_load, aclk, aresetn, ctl.ld_phase, ctl.rd_rom)

endmodule

`default_nettype wire

// File: src/stpg_emitter.sv
`default_nettype none
`include "assert_macros.svh"

module stpg_emitter #(
    parameter int MAX_CHANNELS = stpg_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic signed [31:0] load_val,
    input  wire logic        [31:0] load_packed,
    input  wire logic   [CH_W-1:0]  ch_last,
    output logic                    out_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_sample_value,
    output logic        [31:0]      m_packed_bytes,
    output logic        [2:0]       m_channel_index,
    output logic                    m_last_in_run
);

    logic               valid_reg;
    logic               valid_next;
    logic [CH_W-1:0]    ch_reg;
    logic [CH_W-1:0]    ch_next;
    logic [CH_W-1:0]    last_reg;
    logic signed [31:0] val_reg;
    logic [31:0]        packed_reg;
    logic               is_last;
    logic               take;

    assign is_last  = (ch_reg == last_reg);
    assign take     = valid_reg && m_ready;
    assign out_free = !valid_reg || (take && is_last);

    always_comb begin
        valid_next = valid_reg;
        ch_next    = ch_reg;
        if (load) begin
            valid_next = 1'b1;
            ch_next    = '0;
        end else if (take) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                ch_next = ch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ch_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            val_reg    <= load_val;
            packed_reg <= load_packed;
            last_reg   <= ch_last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_sample_value  = val_reg;
    assign m_packed_bytes  = packed_reg;
    assign m_channel_index = 3'(ch_reg);
    assign m_last_in_run   = is_last;

    `ASSERT_NEXT(a_load_starts_run, aclk, aresetn, load, valid_reg && ch_reg == '0)
    `ASSERT_NEXT(a_run_advances, aclk, aresetn, take && !is_last && !load,
        valid_reg && ch_reg == CH_W'($past(ch_reg) + 1'b1))

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stpg_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic        [31:0] packed_word;
        logic        [2:0]  chan;
        logic               last;
    } tone_copy_t;

    class tone_scoreboard;
        bit [31:0]        step;
        bit [GAIN_W-1:0]  gain;
        bit [2:0]         nbytes;
        bit [3:0]         nchan;
        bit [31:0]        phase_acc;
        bit [MAG_W-1:0]   sine_q17[SINE_ROM_DEPTH_DEF];
        tone_copy_t       due[$];
        int               errors;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned sum;
            longint unsigned r;
            for (int k = 0; k < SINE_ROM_DEPTH_DEF; k++) begin
                x = (HALF_PI_Q30 * longint'(2 * k + 1)) / longint'(2 * SINE_ROM_DEPTH_DEF);
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (longint unsigned n = 1; n <= 12; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = (sum >= term) ? sum - term : 64'd0;
                    end else begin
                        sum = sum + term;
                    end
                end
                r = (sum + 64'd4096) >> 13;
                if (r > longint'(MAG_MAX)) begin
                    r = longint'(MAG_MAX);
                end
                sine_q17[k] = MAG_W'(r);
            end
            step = PHASE_STEP_RST;
            gain = GAIN_RST;
            nbytes = SAMPLE_BYTES_RST;
            nchan = CHANNEL_COUNT_RST;
            phase_acc = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, bit [31:0] v);
            case (idx)
                REG_PHASE_STEP:    step = v;
                REG_GAIN:          gain = v[GAIN_W-1:0];
                REG_SAMPLE_BYTES:  nbytes = v[2:0];
                REG_CHANNEL_COUNT: nchan = v[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_tick(bit restart);
            bit [31:0]       ph;
            bit [1:0]        quad;
            int unsigned     idx;
            longint unsigned prod;
            longint unsigned full;
            longint unsigned mag;
            bit [31:0]       val;
            bit [31:0]       word;
            int              nb;
            int              nc;
            tone_copy_t      c;
            ph = restart ? 32'd0 : phase_acc;
            quad = ph[31:30];
            idx = ph[29:20];
            if (quad[0]) begin
                idx = SINE_ROM_DEPTH_DEF - 1 - idx;
            end
            prod = longint'(sine_q17[idx]) * longint'(gain);
            if (prod > longint'(ONE_Q33)) begin
                prod = longint'(ONE_Q33);
            end
            nb = (nbytes < 1) ? 1 : (nbytes > 4) ? 4 : nbytes;
            full = longint'(32'h7FFF_FFFF >> (8 * (4 - nb)));
            mag = (prod * full) >> 33;
            val = mag[31:0];
            if (quad[1]) begin
                val = -val;
            end
            case (nb)
                1: word = {24'd0, val[7:0] + BYTE_OFFSET};
                4: word = val;
                default: word = val & ((32'd1 << (8 * nb)) - 32'd1);
            endcase
            nc = (nchan < 1) ? 1 : (nchan > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : nchan;
            for (int i = 0; i < nc; i++) begin
                c.value = val;
                c.packed_word = word;
                c.chan = i[2:0];
                c.last = (i == nc - 1);
                due.push_back(c);
            end
            phase_acc = ph + step;
        endfunction

        function void check_copy(tone_copy_t got);
            tone_copy_t exp_c;
            if (due.size() == 0) begin
                $display("%0t: unexpected item value %0d packed %h channel %0d last %0b",
                         $time, got.value, got.packed_word, got.chan, got.last);
                errors++;
                return;
            end
            exp_c = due.pop_front();
            if (got.value !== exp_c.value) begin
                $display("%0t: sample_value expected %0d actual %0d",
                         $time, exp_c.value, got.value);
                errors++;
            end
            if (got.packed_word !== exp_c.packed_word) begin
                $display("%0t: packed_bytes expected %h actual %h",
                         $time, exp_c.packed_word, got.packed_word);
                errors++;
            end
            if (got.chan !== exp_c.chan) begin
                $display("%0t: channel_index expected %0d actual %0d",
                         $time, exp_c.chan, got.chan);
                errors++;
            end
            if (got.last !== exp_c.last) begin
                $display("%0t: last_in_run expected %0b actual %0b",
                         $time, exp_c.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_restart = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_sample_value;
    logic [31:0]           m_packed_bytes;
    logic [2:0]            m_channel_index;
    logic                  m_last_in_run;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int s_idle_pct = 0;
    int m_idle_pct = 0;

    tone_scoreboard sb = new();

    sine_tone_pcm_generator_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_packed_bytes  (m_packed_bytes),
        .m_channel_index (m_channel_index),
        .m_last_in_run   (m_last_in_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        tone_copy_t got;
        if (aresetn && m_valid && m_ready) begin
            got.value = m_sample_value;
            got.packed_word = m_packed_bytes;
            got.chan = m_channel_index;
            got.last = m_last_in_run;
            sb.check_copy(got);
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    task automatic reg_write(reg_idx_t idx, bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(bit [31:0] step, bit [31:0] gain, bit [31:0] nb, bit [31:0] nch);
        settle();
        reg_write(REG_PHASE_STEP, step);
        reg_write(REG_GAIN, gain);
        reg_write(REG_SAMPLE_BYTES, nb);
        reg_write(REG_CHANNEL_COUNT, nch);
    endtask

    task automatic send_tick(bit restart);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < s_idle_pct);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_tick(restart);
    endtask

    task automatic send_ticks(int count, int restart_pct);
        for (int i = 0; i < count; i++) begin
            send_tick($urandom_range(99) < restart_pct);
        end
        s_valid <= 1'b0;
    endtask

    function automatic bit [31:0] pick_step();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h00FF_FFFF);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
            default: return {2'($urandom_range(0, 3)), 30'd0} + 32'($urandom_range(0, 1023));
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        s_idle_pct = 14;
        m_idle_pct = 66;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        s_valid <= 1'b0;

        configure(32'h4000_0000, 32'd131071, 32'd4, 32'd8);
        send_tick(1'b1);
        send_ticks(4, 0);

        configure(32'h4000_0000, 32'd0, 32'd1, 32'd0);
        send_tick(1'b1);
        send_ticks(1, 0);

        configure(32'h4000_0000, 32'd65536, 32'd1, 32'd3);
        send_tick(1'b1);
        send_ticks(3, 0);

        configure(32'hFFFF_FFFF, 32'd98304, 32'd0, 32'd15);
        send_tick(1'b1);
        send_ticks(2, 0);

        configure(32'd0, 32'd40000, 32'd7, 32'd9);
        send_ticks(2, 50);

        for (int m = 0; m < 3; m++) begin
            s_idle_pct = (m == 0) ? 14 : (m == 1) ? 66 : 0;
            m_idle_pct = (m == 0) ? 66 : (m == 1) ? 14 : 0;
            for (int p = 0; p < 4; p++) begin
                configure(pick_step(), $urandom_range(0, 131071), $urandom_range(0, 7),
                          $urandom_range(0, 15));
                send_ticks(8, 10);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
